>>> src/lse_pkg.sv
`timescale 1ns / 1ps

package lse_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam int REQ_W   = 4;
    localparam int OPND_W  = 16;
    localparam int COUNT_W = 11;

    localparam logic [REQ_W-1:0] OP_PUSH    = 4'd0;
    localparam logic [REQ_W-1:0] OP_POP     = 4'd1;
    localparam logic [REQ_W-1:0] OP_PEEK    = 4'd2;
    localparam logic [REQ_W-1:0] OP_CLEAR   = 4'd3;
    localparam logic [REQ_W-1:0] OP_REVERSE = 4'd4;
    localparam logic [REQ_W-1:0] OP_DELETE  = 4'd5;
    localparam logic [REQ_W-1:0] OP_DEDUP   = 4'd6;
    localparam logic [REQ_W-1:0] OP_REVTOP  = 4'd7;
    localparam logic [REQ_W-1:0] OP_MIN     = 4'd8;
    localparam logic [REQ_W-1:0] OP_SYM     = 4'd9;

endpackage

>>> src/lse_if.sv
`timescale 1ns / 1ps

interface lse_req_if;
    import lse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [OPND_W-1:0] operand_value;
    logic [COUNT_W-1:0]       top_count;

    modport source (output valid, req_type, operand_value, top_count, input ready);
    modport sink   (input valid, req_type, operand_value, top_count, output ready);
endinterface

interface lse_rsp_if;
    import lse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     status;
    logic signed [OPND_W-1:0] result_value;
    logic                     is_palindrome;
    logic [COUNT_W-1:0]       fill_level;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, status, result_value, is_palindrome, fill_level,
                    is_empty, is_full, input ready);
    modport sink   (input valid, status, result_value, is_palindrome, fill_level,
                    is_empty, is_full, output ready);
endinterface

>>> src/lifo_stack_engine.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// i_req     in   valid / ready    req_type, operand_value, top_count
// o_rsp     out  valid / ready    status, result_value, is_palindrome, fill_level,
//                                 is_empty, is_full
//
// One request at a time; the entry RAM (one read port and one write port, registered
// read) sets the pace of each request. Reverse and reverse top swap pairs of entries;
// symmetric compares pairs. Delete and min walk each entry in turn. Dedup walks each
// entry, compares it against the kept entries until one matches, and keeps it if none does.
// Reset is synchronous, active low, and empties the stack at once.
// A response stalled on o_rsp holds; a new request is taken as it drains.

module lifo_stack_engine #(
    parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = lse_pkg::VALUE_WIDTH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    lse_req_if.sink   i_req,
    lse_rsp_if.source o_rsp
);
    import lse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_TOP  = 12'b000000000010,
        S_PA   = 12'b000000000100,
        S_PB   = 12'b000000001000,
        S_PC   = 12'b000000010000,
        S_PD   = 12'b000000100000,
        S_IA   = 12'b000001000000,
        S_IB   = 12'b000010000000,
        S_JA   = 12'b000100000000,
        S_JB   = 12'b001000000000,
        S_KEEP = 12'b010000000000,
        S_DONE = 12'b100000000000
    } t_state;

    logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];

    t_state                        r_state, n_state;
    logic [REQ_W-1:0]              r_op, n_op;
    logic [VALUE_WIDTH-1:0]        r_opv, n_opv;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                 r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0]                 r_i, n_i, r_j, n_j, r_w, n_w;
    logic [VALUE_WIDTH-1:0]        r_a, n_a;
    logic signed [VALUE_WIDTH-1:0] r_val, n_val;
    logic signed [VALUE_WIDTH-1:0] r_rd;
    logic                          r_status, n_status, r_pal, n_pal, r_ov, n_ov;

    logic                   acc, take, wr_en, eq, less, last_i;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [VALUE_WIDTH-1:0] wr_data, cmp_b, opv_in;
    logic [CW-1:0]          cnt_m1, span;

    assign i_req.ready = (r_state == S_IDLE) && (!r_ov || o_rsp.ready);
    assign acc  = i_req.valid && i_req.ready;
    assign take = o_rsp.valid && o_rsp.ready;

    assign opv_in = VALUE_WIDTH'(i_req.operand_value);
    assign cnt_m1 = r_cnt - 1'b1;
    assign span   = r_hi - r_lo;
    assign last_i = (r_i + 1'b1) == r_cnt;
    assign cmp_b  = (r_op == OP_DELETE && r_state == S_IB) ? r_opv : r_a;
    assign eq     = r_rd == cmp_b;
    assign less   = r_rd < r_val;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_opv    = r_opv;
        n_cnt    = r_cnt;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_i      = r_i;
        n_j      = r_j;
        n_w      = r_w;
        n_a      = r_a;
        n_val    = r_val;
        n_status = r_status;
        n_pal    = r_pal;
        n_ov     = take ? 1'b0 : r_ov;
        wr_en    = 1'b0;
        wr_addr  = r_w[AW-1:0];
        wr_data  = r_a;
        rd_addr  = r_i[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                rd_addr = cnt_m1[AW-1:0];
                if (acc) begin
                    n_op     = i_req.req_type;
                    n_opv    = opv_in;
                    n_status = 1'b0;
                    n_val    = '0;
                    n_pal    = 1'b0;
                    n_i      = '0;
                    n_w      = '0;
                    n_lo     = '0;
                    n_hi     = cnt_m1;
                    n_state  = S_DONE;
                    case (i_req.req_type)
                        OP_PUSH: begin
                            if (r_cnt == CW'(STACK_DEPTH)) begin
                                n_status = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_cnt[AW-1:0];
                                wr_data = opv_in;
                                n_cnt   = r_cnt + 1'b1;
                            end
                        end
                        OP_POP, OP_PEEK, OP_MIN: begin
                            if (r_cnt == '0) begin
                                n_status = 1'b1;
                            end else begin
                                n_state = (i_req.req_type == OP_MIN) ? S_IA : S_TOP;
                            end
                        end
                        OP_CLEAR: n_cnt = '0;
                        OP_REVERSE: begin
                            if (r_cnt > CW'(1)) n_state = S_PA;
                        end
                        OP_DELETE, OP_DEDUP: begin
                            if (r_cnt != '0) n_state = S_IA;
                        end
                        OP_REVTOP: begin
                            if (32'(i_req.top_count) > 32'(r_cnt)) begin
                                n_status = 1'b1;
                            end else if (i_req.top_count > COUNT_W'(1)) begin
                                n_lo    = r_cnt - CW'(i_req.top_count);
                                n_state = S_PA;
                            end
                        end
                        OP_SYM: begin
                            n_pal = 1'b1;
                            if (r_cnt > CW'(1)) n_state = S_PA;
                        end
                        default: n_status = 1'b1;
                    endcase
                end
            end
            S_TOP: begin
                n_val = r_rd;
                if (r_op == OP_POP) n_cnt = cnt_m1;
                n_state = S_DONE;
            end
            S_PA: begin
                rd_addr = r_lo[AW-1:0];
                n_state = S_PB;
            end
            S_PB: begin
                rd_addr = r_hi[AW-1:0];
                n_a     = r_rd;
                n_state = S_PC;
            end
            S_PC: begin
                if (r_op == OP_SYM) begin
                    if (!eq) begin
                        n_pal   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_lo    = r_lo + 1'b1;
                        n_hi    = r_hi - 1'b1;
                        n_state = (span > CW'(2)) ? S_PA : S_DONE;
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_lo[AW-1:0];
                    wr_data = r_rd;
                    n_state = S_PD;
                end
            end
            S_PD: begin
                wr_en   = 1'b1;
                wr_addr = r_hi[AW-1:0];
                wr_data = r_a;
                n_lo    = r_lo + 1'b1;
                n_hi    = r_hi - 1'b1;
                n_state = (span > CW'(2)) ? S_PA : S_DONE;
            end
            S_IA: begin
                n_state = S_IB;
            end
            S_IB: begin
                priority if (r_op == OP_MIN) begin
                    if (r_i == '0 || less) n_val = r_rd;
                    n_i     = r_i + 1'b1;
                    n_state = last_i ? S_DONE : S_IA;
                end else if (r_op == OP_DELETE) begin
                    if (!eq) begin
                        wr_en   = 1'b1;
                        wr_data = r_rd;
                        n_w     = r_w + 1'b1;
                    end
                    n_i = r_i + 1'b1;
                    if (last_i) begin
                        n_cnt   = eq ? r_w : r_w + 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IA;
                    end
                end else begin
                    n_a     = r_rd;
                    n_j     = '0;
                    n_state = (r_w == '0) ? S_KEEP : S_JA;
                end
            end
            S_JA: begin
                rd_addr = r_j[AW-1:0];
                n_state = S_JB;
            end
            S_JB: begin
                if (eq) begin
                    n_i = r_i + 1'b1;
                    if (last_i) begin
                        n_cnt   = r_w;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IA;
                    end
                end else if ((r_j + 1'b1) == r_w) begin
                    n_state = S_KEEP;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_JA;
                end
            end
            S_KEEP: begin
                wr_en = 1'b1;
                n_w   = r_w + 1'b1;
                n_i   = r_i + 1'b1;
                if (last_i) begin
                    n_cnt   = r_w + 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_IA;
                end
            end
            S_DONE: begin
                n_ov    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_opv    <= n_opv;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_i      <= n_i;
        r_j      <= n_j;
        r_w      <= n_w;
        r_a      <= n_a;
        r_val    <= n_val;
        r_status <= n_status;
        r_pal    <= n_pal;
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_status;
    assign o_rsp.result_value  = OPND_W'(r_val);
    assign o_rsp.is_palindrome = r_pal;
    assign o_rsp.fill_level    = COUNT_W'(r_cnt);
    assign o_rsp.is_empty      = r_cnt == '0;
    assign o_rsp.is_full       = r_cnt == CW'(STACK_DEPTH);

endmodule

>>> src/lse_chk.sv
`timescale 1ns / 1ps

module lse_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_req_valid,
    input logic                                i_req_ready,
    input logic                                i_rsp_valid,
    input logic                                i_rsp_ready,
    input logic [lse_pkg::COUNT_W-1:0]         i_fill_level,
    input logic                                i_is_empty,
    input logic                                i_is_full,
    input logic signed [lse_pkg::OPND_W-1:0]   i_result_value
);
    import lse_pkg::*;

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_is_empty == (i_fill_level == '0)))
        else $error("empty flag disagrees with fill level");

    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_is_full && i_is_empty))
        else $error("full and empty together");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |-> !(i_req_valid && i_req_ready))
        else $error("request taken while response stalled");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_fill_level) && $stable(i_result_value)))
        else $error("stalled response changed");

endmodule

bind lifo_stack_engine lse_chk u_lse_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_fill_level   (o_rsp.fill_level),
    .i_is_empty     (o_rsp.is_empty),
    .i_is_full      (o_rsp.is_full),
    .i_result_value (o_rsp.result_value)
);

>>> test/lifo_stack_engine_tb.sv
`timescale 1ns / 1ps

module lifo_stack_engine_tb;
    import lse_pkg::*;

    localparam int DEPTH      = STACK_DEPTH_DEF;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic                     status;
        logic signed [OPND_W-1:0] value;
        logic                     pal;
        logic [COUNT_W-1:0]       fill;
        logic                     empty;
        logic                     full;
    } stack_rsp_t;

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   fail_cnt;
    int   stall_cnt;
    int   ready_hold;

    lse_req_if i_req ();
    lse_rsp_if o_rsp ();

    lifo_stack_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.sink),
        .o_rsp   (o_rsp.source)
    );

    logic signed [OPND_W-1:0] shadow_stack [0:DEPTH-1];
    int                       shadow_fill;
    stack_rsp_t               pending_rsp [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic stack_rsp_t stack_apply(logic [REQ_W-1:0] req,
                                               logic signed [OPND_W-1:0] opnd,
                                               logic [COUNT_W-1:0] k);
        stack_rsp_t r;
        logic signed [OPND_W-1:0] t;
        int n;
        int w;
        int lo;
        int hi;
        bit seen;
        r = '0;
        n = shadow_fill;
        case (req)
            OP_PUSH: begin
                if (n >= DEPTH) r.status = 1'b1;
                else begin
                    shadow_stack[n] = opnd;
                    shadow_fill = n + 1;
                end
            end
            OP_POP: begin
                if (n == 0) r.status = 1'b1;
                else begin
                    r.value = shadow_stack[n-1];
                    shadow_fill = n - 1;
                end
            end
            OP_PEEK: begin
                if (n == 0) r.status = 1'b1;
                else r.value = shadow_stack[n-1];
            end
            OP_CLEAR: shadow_fill = 0;
            OP_REVERSE, OP_REVTOP: begin
                lo = 0;
                hi = n - 1;
                if (req == OP_REVTOP) begin
                    if (k > n) begin
                        r.status = 1'b1;
                        hi = -1;
                    end else lo = n - k;
                end
                while (lo < hi) begin
                    t = shadow_stack[lo];
                    shadow_stack[lo] = shadow_stack[hi];
                    shadow_stack[hi] = t;
                    lo++;
                    hi--;
                end
            end
            OP_DELETE: begin
                w = 0;
                for (int i = 0; i < n; i++)
                    if (shadow_stack[i] != opnd) shadow_stack[w++] = shadow_stack[i];
                shadow_fill = w;
            end
            OP_DEDUP: begin
                w = 0;
                for (int i = 0; i < n; i++) begin
                    seen = 1'b0;
                    for (int j = 0; j < w; j++)
                        if (shadow_stack[j] == shadow_stack[i]) seen = 1'b1;
                    if (!seen) shadow_stack[w++] = shadow_stack[i];
                end
                shadow_fill = w;
            end
            OP_MIN: begin
                if (n == 0) r.status = 1'b1;
                else begin
                    r.value = shadow_stack[0];
                    for (int i = 1; i < n; i++)
                        if (shadow_stack[i] < r.value) r.value = shadow_stack[i];
                end
            end
            OP_SYM: begin
                r.pal = 1'b1;
                for (int i = 0; i < n / 2; i++)
                    if (shadow_stack[i] != shadow_stack[n-1-i]) r.pal = 1'b0;
            end
            default: r.status = 1'b1;
        endcase
        r.fill  = COUNT_W'(shadow_fill);
        r.empty = (shadow_fill == 0);
        r.full  = (shadow_fill >= DEPTH);
        return r;
    endfunction

    task automatic send_req(logic [REQ_W-1:0] req, logic signed [OPND_W-1:0] opnd = '0,
                            logic [COUNT_W-1:0] k = '0);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_req.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_req.valid         <= 1'b1;
        i_req.req_type      <= req;
        i_req.operand_value <= opnd;
        i_req.top_count     <= k;
        @(posedge i_clk);
        while (!i_req.ready) @(posedge i_clk);
        pending_rsp.push_back(stack_apply(req, opnd, k));
    endtask

    always @(posedge i_clk) begin
        stack_rsp_t want;
        if (i_rst_n && o_rsp.valid && o_rsp.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response, fill %0d", $time, o_rsp.fill_level);
                fail_cnt++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, o_rsp.status);
                    fail_cnt++;
                end
                if (o_rsp.result_value !== want.value) begin
                    $display("%0t: result_value exp %0d got %0d", $time, want.value,
                             o_rsp.result_value);
                    fail_cnt++;
                end
                if (o_rsp.is_palindrome !== want.pal) begin
                    $display("%0t: is_palindrome exp %0d got %0d", $time, want.pal,
                             o_rsp.is_palindrome);
                    fail_cnt++;
                end
                if (o_rsp.fill_level !== want.fill) begin
                    $display("%0t: fill_level exp %0d got %0d", $time, want.fill,
                             o_rsp.fill_level);
                    fail_cnt++;
                end
                if (o_rsp.is_empty !== want.empty) begin
                    $display("%0t: is_empty exp %0d got %0d", $time, want.empty,
                             o_rsp.is_empty);
                    fail_cnt++;
                end
                if (o_rsp.is_full !== want.full) begin
                    $display("%0t: is_full exp %0d got %0d", $time, want.full, o_rsp.is_full);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        o_rsp.ready = 1'b0;
        ready_hold  = 0;
        forever begin
            @(negedge i_clk);
            if (!quiet && ready_hold > 0) begin
                o_rsp.ready <= 1'b0;
                ready_hold--;
            end else begin
                o_rsp.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) ready_hold = $urandom_range(1, 5);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_req.valid && i_req.ready) || (o_rsp.valid && o_rsp.ready)) stall_cnt = 0;
        else stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_basic_ops();
        send_req(OP_SYM);
        send_req(OP_PUSH, 16'sh7fff);
        send_req(OP_PUSH, 16'sh8000);
        send_req(OP_PUSH, 16'sd0);
        send_req(OP_PUSH, -16'sd1);
        send_req(OP_PEEK);
        send_req(OP_MIN);
        send_req(OP_REVTOP, '0, 11'd0);
        send_req(OP_REVTOP, '0, 11'd1);
        send_req(OP_REVTOP, '0, 11'd3);
        send_req(OP_REVTOP, '0, 11'd5);
        send_req(OP_REVERSE);
        send_req(OP_SYM);
        send_req(OP_DELETE, 16'sd5);
        send_req(OP_DELETE, 16'sh7fff);
        send_req(OP_PUSH, -16'sd1);
        send_req(OP_DEDUP);
        send_req(OP_DEDUP);
        send_req(OP_POP);
        send_req(OP_CLEAR);
        send_req(OP_POP);
        send_req(OP_PEEK);
        send_req(OP_MIN);
        send_req(OP_REVERSE);
        send_req(4'd10);
        send_req(4'd15);
    endtask

    task automatic test_full_stack();
        for (int i = 0; i < DEPTH; i++) send_req(OP_PUSH, OPND_W'((i % 8) - 4));
        send_req(OP_PUSH, 16'sd9);
        send_req(OP_REVTOP, '0, 11'd1024);
        send_req(OP_REVTOP, '0, 11'd1025);
        send_req(OP_REVTOP, '0, 11'h7ff);
        send_req(OP_REVERSE);
        send_req(OP_MIN);
        send_req(OP_SYM);
        send_req(OP_DELETE, -16'sd4);
        send_req(OP_DEDUP);
        send_req(OP_CLEAR);
    endtask

    task automatic test_random_mix(int n_items);
        int pick;
        int len;
        logic signed [OPND_W-1:0] v;
        logic signed [OPND_W-1:0] seq [$];
        for (int it = 0; it < n_items; it++) begin
            if (it >= n_items - 150) quiet = 1'b1;
            v = ($urandom_range(0, 1) == 0) ? OPND_W'($urandom_range(0, 7) - 4) :
                                              OPND_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                seq.delete();
                len = $urandom_range(0, 6);
                send_req(OP_CLEAR);
                for (int i = 0; i < len; i++) begin
                    seq.push_back(($urandom_range(0, 1) == 0) ? OPND_W'($urandom) :
                                  OPND_W'($urandom_range(0, 3)));
                    send_req(OP_PUSH, seq[i]);
                end
                if ($urandom_range(0, 1) == 0) send_req(OP_PUSH, OPND_W'($urandom));
                for (int i = len - 1; i >= 0; i--) send_req(OP_PUSH, seq[i]);
                send_req(OP_SYM);
                it += 2 * len + 2;
            end else if (pick < 40) begin
                if (shadow_fill > 48) send_req(OP_POP);
                else send_req(OP_PUSH, v);
            end else if (pick < 55) send_req(OP_POP, OPND_W'($urandom));
            else if (pick < 61) send_req(OP_PEEK, OPND_W'($urandom), COUNT_W'($urandom));
            else if (pick < 63) send_req(OP_CLEAR);
            else if (pick < 67) send_req(OP_REVERSE);
            else if (pick < 74) begin
                if (shadow_fill > 0 && $urandom_range(0, 2) != 0)
                    v = shadow_stack[$urandom_range(0, shadow_fill - 1)];
                send_req(OP_DELETE, v);
            end else if (pick < 78) send_req(OP_DEDUP);
            else if (pick < 88) begin
                if ($urandom_range(0, 7) == 0) send_req(OP_REVTOP, v, COUNT_W'($urandom));
                else send_req(OP_REVTOP, v, COUNT_W'($urandom_range(0, shadow_fill + 2)));
            end else if (pick < 93) send_req(OP_MIN);
            else if (pick < 97) send_req(OP_SYM);
            else send_req(REQ_W'($urandom_range(10, 15)), OPND_W'($urandom),
                          COUNT_W'($urandom));
        end
    endtask

    initial begin
        quiet               = 1'b0;
        fail_cnt            = 0;
        stall_cnt           = 0;
        shadow_fill         = 0;
        i_rst_n             = 1'b0;
        i_req.valid         = 1'b0;
        i_req.req_type      = OP_PUSH;
        i_req.operand_value = '0;
        i_req.top_count     = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_basic_ops();
        test_full_stack();
        test_random_mix(490);
        @(negedge i_clk);
        i_req.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
